FILE: rtl/dps_pkg.sv
package dps_pkg;

	localparam int ID_W         = 64;
	localparam int NS_W         = 16;
	localparam int CNT_W        = 6;
	localparam int CAPACITY_DEF = 32;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_LIST  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ADD     = 2'd0,
		KIND_CLEAR   = 2'd1,
		KIND_ENTRY   = 2'd2,
		KIND_SUMMARY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_ADDED   = 2'd0,
		ST_PRESENT = 2'd1,
		ST_REJECT  = 2'd2
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0] lo;
		logic [ID_W-1:0] hi;
		logic [NS_W-1:0] ns;
	} entry_t;

	typedef struct packed {
		kind_t            kind;
		status_t          status;
		logic [ID_W-1:0]  low_id;
		logic [ID_W-1:0]  high_id;
		logic [NS_W-1:0]  ns;
		logic [CNT_W-1:0] stored;
		logic             trunc;
		logic [CNT_W-1:0] matched;
		logic [CNT_W-1:0] written;
		logic             last;
	} res_t;

endpackage

FILE: rtl/dedup_pair_set_core.sv
// Channel   Signals                                          Handshake
// -------   -----------------------------------------------  -------------------------------
// command   command, first_id, second_id, namespace_tag,     beat taken when start && !busy
//           list_limit
// result    kind, status, low_id, high_id, entry_namespace,  valid high for one cycle per beat
//           stored_count, truncated_flag, matched_total,
//           written_count, last
//
// Clear, an add of an invalid pair and the unused command code are handled in idle; busy stays low.
// A valid add keeps busy high while the held pairs are scanned, ending early when a duplicate
// is found, and a list while every held pair is scanned: the single read port of the pair
// memory scans one entry a cycle. Each result is registered at the edge that updates the
// state and sits on the ports for the following cycle, so a new command may be taken while the
// last result of the previous one is on the ports.
// arst_n clears the count, the overflow flag and the sequencer; the pair memory is not cleared.
// The receiver cannot stall: every result beat lasts exactly one cycle.
module dedup_pair_set_core #(
	parameter int CAPACITY = dps_pkg::CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 command,
	input  logic [dps_pkg::ID_W-1:0]   first_id,
	input  logic [dps_pkg::ID_W-1:0]   second_id,
	input  logic [dps_pkg::NS_W-1:0]   namespace_tag,
	input  logic [dps_pkg::CNT_W-1:0]  list_limit,
	output logic                       valid,
	output logic [1:0]                 kind,
	output logic [1:0]                 status,
	output logic [dps_pkg::ID_W-1:0]   low_id,
	output logic [dps_pkg::ID_W-1:0]   high_id,
	output logic [dps_pkg::NS_W-1:0]   entry_namespace,
	output logic [dps_pkg::CNT_W-1:0]  stored_count,
	output logic                       truncated_flag,
	output logic [dps_pkg::CNT_W-1:0]  matched_total,
	output logic [dps_pkg::CNT_W-1:0]  written_count,
	output logic                       last
);
	import dps_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_LIST
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] held_q;
	logic             ovf_q;
	logic [CNT_W-1:0] idx_q;
	logic             pend_q;
	logic [ID_W-1:0]  lo_q;
	logic [ID_W-1:0]  hi_q;
	logic [NS_W-1:0]  ns_q;
	logic [CNT_W-1:0] limit_q;
	logic [CNT_W-1:0] matched_q;
	logic [CNT_W-1:0] written_q;
	logic             valid_q;
	res_t             res_q;

	entry_t           pair_mem [CAPACITY];
	entry_t           rd_data_q;
	entry_t           wr_entry;

	logic             id_bad;
	logic             id_swap;
	logic             rd_en;
	logic             scan_done;
	logic             is_full;
	logic             dup_hit;
	logic             ns_hit;
	logic             mem_we;
	logic             emit;
	res_t             res_n;

	assign id_bad  = (first_id == '0) || (second_id == '0) || (first_id == second_id);
	assign id_swap = first_id > second_id;

	assign rd_en     = ((state_q == S_ADD) || (state_q == S_LIST)) && (idx_q < held_q);
	// All issued reads have been compared once nothing is in flight and nothing is left.
	assign scan_done = !pend_q && !rd_en;
	assign is_full   = held_q >= CAP_CNT;
	assign dup_hit   = pend_q && (rd_data_q.lo == lo_q) && (rd_data_q.hi == hi_q);
	assign ns_hit    = (ns_q == '0) || (rd_data_q.ns == ns_q);
	assign mem_we    = (state_q == S_ADD) && scan_done && !is_full;

	assign wr_entry = '{lo: lo_q, hi: hi_q, ns: ns_q};

	always_comb begin
		emit          = 1'b0;
		res_n         = '0;
		res_n.kind    = KIND_ADD;
		res_n.status  = ST_ADDED;
		res_n.stored  = held_q;
		res_n.trunc   = ovf_q;
		res_n.last    = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (command)
						CMD_ADD: begin
							if (id_bad) begin
								emit         = 1'b1;
								res_n.status = ST_REJECT;
							end
						end
						CMD_CLEAR: begin
							emit         = 1'b1;
							res_n.kind   = KIND_CLEAR;
							res_n.stored = '0;
							res_n.trunc  = 1'b0;
						end
						default: ;
					endcase
				end
			end
			S_ADD: begin
				if (dup_hit) begin
					emit         = 1'b1;
					res_n.status = ST_PRESENT;
				end else if (scan_done) begin
					emit = 1'b1;
					if (is_full) begin
						res_n.status = ST_REJECT;
						res_n.trunc  = 1'b1;
					end else begin
						res_n.stored = held_q + CNT_W'(1);
					end
				end
			end
			S_LIST: begin
				if (scan_done) begin
					emit          = 1'b1;
					res_n.kind    = KIND_SUMMARY;
					res_n.matched = matched_q;
					res_n.written = written_q;
				end else if (pend_q && ns_hit && (written_q < limit_q)) begin
					emit          = 1'b1;
					res_n.kind    = KIND_ENTRY;
					res_n.low_id  = rd_data_q.lo;
					res_n.high_id = rd_data_q.hi;
					res_n.ns      = rd_data_q.ns;
					res_n.last    = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pair_mem[held_q[IDX_W-1:0]] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= pair_mem[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			held_q    <= '0;
			ovf_q     <= 1'b0;
			idx_q     <= '0;
			pend_q    <= 1'b0;
			matched_q <= '0;
			written_q <= '0;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= emit;
			if (emit) begin
				res_q <= res_n;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q  <= '0;
						pend_q <= 1'b0;
						case (command)
							CMD_ADD: begin
								lo_q <= id_swap ? second_id : first_id;
								hi_q <= id_swap ? first_id : second_id;
								ns_q <= namespace_tag;
								if (!id_bad) begin
									state_q <= S_ADD;
								end
							end
							CMD_CLEAR: begin
								held_q <= '0;
								ovf_q  <= 1'b0;
							end
							CMD_LIST: begin
								ns_q      <= namespace_tag;
								limit_q   <= list_limit;
								matched_q <= '0;
								written_q <= '0;
								state_q   <= S_LIST;
							end
							default: ;
						endcase
					end
				end
				S_ADD: begin
					if (rd_en) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					pend_q <= rd_en;
					if (dup_hit) begin
						state_q <= S_IDLE;
					end else if (scan_done) begin
						if (is_full) begin
							ovf_q <= 1'b1;
						end else begin
							held_q <= held_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_LIST: begin
					if (rd_en) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					pend_q <= rd_en;
					if (pend_q && ns_hit) begin
						matched_q <= matched_q + CNT_W'(1);
						if (written_q < limit_q) begin
							written_q <= written_q + CNT_W'(1);
						end
					end
					if (scan_done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign valid           = valid_q;
	assign kind            = res_q.kind;
	assign status          = res_q.status;
	assign low_id          = res_q.low_id;
	assign high_id         = res_q.high_id;
	assign entry_namespace = res_q.ns;
	assign stored_count    = res_q.stored;
	assign truncated_flag  = res_q.trunc;
	assign matched_total   = res_q.matched;
	assign written_count   = res_q.written;
	assign last            = res_q.last;

endmodule
